[src/erwd_pkg.sv]
package erwd_pkg;

  typedef enum logic [2:0] {
    PH_BIRTH,
    PH_COUNT,
    PH_GROUP,
    PH_DAYS,
    PH_MINS,
    PH_CODE,
    PH_VALUE,
    PH_TRAIL
  } phase_t;

  localparam logic [12:0] MINUTES_PER_DAY = 13'd1440;
  localparam logic [12:0] TWO_DAYS_MINUTES = 13'd2880;
  // 2^32 mod 1440 is 256, so a wrapped sum is corrected by adding 1440 - 256.
  localparam logic [12:0] WRAP_FIX = 13'd1184;

  localparam logic [1:0] CK_NONE     = 2'd0;
  localparam logic [1:0] CK_TEXT     = 2'd1;
  localparam logic [1:0] CK_INT      = 2'd2;
  localparam logic [1:0] CK_NUM_TEXT = 2'd3;

  localparam logic [2:0] VK_NONE     = 3'd0;
  localparam logic [2:0] VK_UNIQUE   = 3'd1;
  localparam logic [2:0] VK_SHARED   = 3'd2;
  localparam logic [2:0] VK_INT      = 3'd3;
  localparam logic [2:0] VK_NUM_TEXT = 3'd4;

  typedef struct packed {
    logic [31:0] data_word;
    logic        end_of_record;
    logic [10:0] word_mod;
  } word_t;

  typedef struct packed {
    logic        event_present;
    logic [31:0] birth_days;
    logic [31:0] age_days;
    logic [10:0] minute_of_day;
    logic [29:0] event_code;
    logic [2:0]  value_kind;
    logic [31:0] value_word;
    logic        record_done;
    logic        format_error;
  } result_t;

endpackage

[src/erwd_word_if.sv]
interface erwd_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        end_of_record;

  modport source (output valid, output data_word, output end_of_record, input ready);
  modport sink (input valid, input data_word, input end_of_record, output ready);
endinterface

[src/erwd_result_if.sv]
interface erwd_result_if;
  logic        valid;
  logic        ready;
  logic        event_present;
  logic [31:0] birth_days;
  logic [31:0] age_days;
  logic [10:0] minute_of_day;
  logic [29:0] event_code;
  logic [2:0]  value_kind;
  logic [31:0] value_word;
  logic        record_done;
  logic        format_error;

  modport source (
    output valid, output event_present, output birth_days, output age_days,
    output minute_of_day, output event_code, output value_kind, output value_word,
    output record_done, output format_error, input ready
  );
  modport sink (
    input valid, input event_present, input birth_days, input age_days,
    input minute_of_day, input event_code, input value_kind, input value_word,
    input record_done, input format_error, output ready
  );
endinterface

[src/erwd_min_mod.sv]
module erwd_min_mod import erwd_pkg::*; (
  input  logic [31:0] data_word,
  output logic [10:0] word_mod
);

  logic [26:0] upper;
  logic [13:0] fold1;
  logic [12:0] fold2;
  logic [23:0] prod;
  logic [6:0]  quot;
  logic [12:0] quot45;
  logic [12:0] rem0;
  logic [5:0]  rem45;

  // 1440 is 32 * 45, and 4096 is 1 modulo 45, so the upper bits fold in 12-bit chunks.
  always_comb begin
    upper  = data_word[31:5];
    fold1  = 14'(upper[11:0]) + 14'(upper[23:12]) + 14'(upper[26:24]);
    fold2  = 13'(fold1[11:0]) + 13'(fold1[13:12]);
    prod   = 24'(fold2) * 24'd1456;
    quot   = prod[22:16];
    quot45 = 13'(quot) * 13'd45;
    rem0   = fold2 - quot45;
    if (rem0 >= 13'd45) begin
      rem45 = 6'(rem0 - 13'd45);
    end else begin
      rem45 = rem0[5:0];
    end
    word_mod = {rem45, data_word[4:0]};
  end

endmodule

[src/erwd_parser.sv]
module erwd_parser import erwd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  word_t   item,
  output logic    emit,
  output result_t result
);

  phase_t      phase, phase_next;
  logic [31:0] events_remaining, events_remaining_next;
  logic [31:0] same_time_remaining, same_time_remaining_next;
  logic [31:0] running_age, running_age_next;
  logic [10:0] running_minutes, running_minutes_next;
  logic [31:0] held_birth_days, held_birth_days_next;
  logic [29:0] held_code, held_code_next;
  logic [1:0]  held_kind, held_kind_next;

  logic        finished;
  logic        extra;
  logic [2:0]  kind_out;
  logic [31:0] val_out;
  logic [29:0] code_now;
  logic [32:0] wide_sum;
  logic [12:0] min_sum0;
  logic [12:0] min_sum1;
  logic [10:0] min_sum;

  always_comb begin
    wide_sum = {1'b0, 21'd0, running_minutes} + {1'b0, item.data_word};
    min_sum0 = 13'(running_minutes) + 13'(item.word_mod);
    min_sum1 = wide_sum[32] ? (min_sum0 + WRAP_FIX) : min_sum0;
    if (min_sum1 >= TWO_DAYS_MINUTES) begin
      min_sum = 11'(min_sum1 - TWO_DAYS_MINUTES);
    end else if (min_sum1 >= MINUTES_PER_DAY) begin
      min_sum = 11'(min_sum1 - MINUTES_PER_DAY);
    end else begin
      min_sum = min_sum1[10:0];
    end
  end

  always_comb begin
    phase_next               = phase;
    events_remaining_next    = events_remaining;
    same_time_remaining_next = same_time_remaining;
    running_age_next         = running_age;
    running_minutes_next     = running_minutes;
    held_birth_days_next     = held_birth_days;
    held_code_next           = held_code;
    held_kind_next           = held_kind;
    finished                 = 1'b0;
    extra                    = 1'b0;
    kind_out                 = VK_NONE;
    val_out                  = 32'd0;
    code_now                 = held_code;

    case (phase)
      PH_BIRTH: begin
        held_birth_days_next = item.data_word;
        phase_next           = PH_COUNT;
      end
      PH_COUNT: begin
        events_remaining_next    = item.data_word;
        same_time_remaining_next = 32'd0;
        running_age_next         = 32'd0;
        running_minutes_next     = 11'd0;
        phase_next               = (item.data_word == 32'd0) ? PH_TRAIL : PH_GROUP;
      end
      PH_GROUP: begin
        same_time_remaining_next = item.data_word;
        phase_next               = PH_DAYS;
      end
      PH_DAYS: begin
        running_age_next = running_age + item.data_word;
        phase_next       = PH_MINS;
      end
      PH_MINS: begin
        running_minutes_next = min_sum;
        phase_next           = PH_CODE;
      end
      PH_CODE: begin
        held_code_next = item.data_word[31:2];
        held_kind_next = item.data_word[1:0];
        code_now       = item.data_word[31:2];
        if (item.data_word[1:0] == CK_NONE) begin
          finished = 1'b1;
        end else begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        case (held_kind)
          CK_TEXT: begin
            kind_out = item.data_word[0] ? VK_SHARED : VK_UNIQUE;
            val_out  = {1'b0, item.data_word[31:1]};
          end
          CK_INT: begin
            kind_out = VK_INT;
            val_out  = item.data_word;
          end
          CK_NUM_TEXT: begin
            kind_out = VK_NUM_TEXT;
            val_out  = item.data_word;
          end
          default: begin
            kind_out = VK_NONE;
            val_out  = 32'd0;
          end
        endcase
        finished = 1'b1;
      end
      default: begin
        extra = 1'b1;
      end
    endcase

    if (finished) begin
      events_remaining_next = events_remaining - 32'd1;
      if (events_remaining_next == 32'd0) begin
        phase_next = PH_TRAIL;
      end else if (same_time_remaining == 32'd0) begin
        phase_next = PH_GROUP;
      end else begin
        same_time_remaining_next = same_time_remaining - 32'd1;
        phase_next               = PH_CODE;
      end
    end

    emit                 = finished || item.end_of_record;
    result.event_present = finished;
    result.birth_days    = finished ? held_birth_days : 32'd0;
    result.age_days      = finished ? running_age : 32'd0;
    result.minute_of_day = finished ? running_minutes : 11'd0;
    result.event_code    = finished ? code_now : 30'd0;
    result.value_kind    = kind_out;
    result.value_word    = val_out;
    result.record_done   = item.end_of_record;
    result.format_error  = item.end_of_record && !((phase_next == PH_TRAIL) && !extra);
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_record)) begin
      phase               <= PH_BIRTH;
      events_remaining    <= 32'd0;
      same_time_remaining <= 32'd0;
      running_age         <= 32'd0;
      running_minutes     <= 11'd0;
      held_birth_days     <= 32'd0;
      held_code           <= 30'd0;
      held_kind           <= CK_NONE;
    end else if (step) begin
      phase               <= phase_next;
      events_remaining    <= events_remaining_next;
      same_time_remaining <= same_time_remaining_next;
      running_age         <= running_age_next;
      running_minutes     <= running_minutes_next;
      held_birth_days     <= held_birth_days_next;
      held_code           <= held_code_next;
      held_kind           <= held_kind_next;
    end
  end

endmodule

[src/event_record_word_decoder.sv]
// Event record word decoder.
// The words channel takes one 32-bit word of a serialised event record per
// item, with end_of_record set on the last word of the record. The events
// channel gives one item for each finished event and one for the ending word
// of a record; an ending word that also finishes an event gives a single item.
// Words that cause no result are consumed silently.
// Every word goes into an input register, is decoded by one pass of logic and
// its result, if any, lands in an output register. A word can be accepted in
// every cycle while the receiver does not stall; the decode pass, with its
// modulo-1440 minute update, sets that figure.
// When the receiver stalls, the held result waits in the output register and
// the input register still fills, so the words channel stops only after one
// further word. Synchronous reset empties both registers and returns the
// parser to expect the birth-day word of a new record; every ending word does
// the same to the parser state.
module event_record_word_decoder import erwd_pkg::*; (
  input logic          clk,
  input logic          rst,
  erwd_word_if.sink    words,
  erwd_result_if.source events
);

  word_t       in_word;
  logic [10:0] word_mod;
  word_t       s1_item;
  logic        s1_valid;
  logic        advance;
  logic        step;
  logic        emit;
  result_t     res;
  result_t     out_res;
  logic        out_valid;

  erwd_min_mod u_min_mod (
    .data_word (words.data_word),
    .word_mod  (word_mod)
  );

  assign in_word = {words.data_word, words.end_of_record, word_mod};

  assign advance     = !out_valid || events.ready;
  assign step        = s1_valid && advance;
  assign words.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (words.ready) begin
      s1_valid <= words.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (words.valid && words.ready) begin
      s1_item <= in_word;
    end
  end

  erwd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .emit   (emit),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && emit) begin
      out_res <= res;
    end
  end

  assign events.valid         = out_valid;
  assign events.event_present = out_res.event_present;
  assign events.birth_days    = out_res.birth_days;
  assign events.age_days      = out_res.age_days;
  assign events.minute_of_day = out_res.minute_of_day;
  assign events.event_code    = out_res.event_code;
  assign events.value_kind    = out_res.value_kind;
  assign events.value_word    = out_res.value_word;
  assign events.record_done   = out_res.record_done;
  assign events.format_error  = out_res.format_error;

endmodule
